// ----- sv/xrs128_pkg.sv -----
// ----------------------------------------------------------------------------
// xrs128_pkg
// Types and constants shared by the xoroshiro128+ generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrs128_pkg;

  // Word kinds on the input channel.
  localparam logic [1:0] KIND_SEED = 2'd0;
  localparam logic [1:0] KIND_NEXT = 2'd1;
  localparam logic [1:0] KIND_JUMP = 2'd2;

  // Generator rotations and shift.
  localparam int unsigned ROT_A   = 55;
  localparam int unsigned SHIFT_B = 14;
  localparam int unsigned ROT_C   = 36;

  // Fraction taken from the top of the value.
  localparam int unsigned FRACTION_SHIFT = 12;
  localparam int unsigned FRACTION_WIDTH = 52;

  // Seed mixing constants.
  localparam logic [63:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_0  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_1  = 64'h94d0_49bb_1331_11eb;
  localparam int unsigned MIX_SH_0   = 30;
  localparam int unsigned MIX_SH_1   = 27;
  localparam int unsigned MIX_SH_2   = 31;

  // Jump polynomial: bit n of this word is polynomial bit n of the sweep.
  localparam logic [127:0] JUMP_POLY = {64'hd86b_048b_86aa_9922, 64'hbeac_0467_eba5_facb};
  localparam logic [6:0]   JUMP_LAST = 7'd127;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_XS,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_FIN,
    ST_JUMP
  } state_t;

endpackage

`default_nettype wire

// ----- sv/xoroshiro128_plus_generator.sv -----
// ----------------------------------------------------------------------------
// xoroshiro128_plus_generator
// xoroshiro128+ generator with seed, next and jump commands.
// ----------------------------------------------------------------------------
//
//  channel | ports                               | direction | handshake
//  --------+-------------------------------------+-----------+---------------
//  in      | in_kind, in_seed_value              | to block  | in_valid/ready
//  out     | out_random_value, out_unit_fraction | from block| out_valid/ready
//
//  A next word is handled in its acceptance cycle and its result is in the
//  output register in the next cycle, so next words may flow every cycle
//  while the output is taken. A seed word runs two splitmix64 mixes of ten
//  steps each, both multiplications going through one 32x32 multiplier in
//  three partial products. A jump word takes one generator step per polynomial
//  bit, but for the last. Unused kinds answer at once with a zero result.
//  Reset (synchronous, rst_n low) clears the state to zero and empties the
//  output register. The input is held off while a seed or jump runs and
//  while the output register holds a word that is not being taken.
//
`default_nettype none

module xoroshiro128_plus_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_random_value,
  output logic [51:0]      out_unit_fraction
);

  xrs128_pkg::state_t state_r, state_nxt;

  logic [63:0] word_zero_r, word_zero_nxt;
  logic [63:0] word_one_r, word_one_nxt;
  logic [63:0] acc_zero_r, acc_zero_nxt;
  logic [63:0] acc_one_r, acc_one_nxt;
  logic [6:0]  jump_cnt_r, jump_cnt_nxt;

  // Mix working value, partial product accumulator and step flags.
  logic [63:0] mix_z_r, mix_z_nxt;
  logic [63:0] mul_acc_r, mul_acc_nxt;
  logic        round_r, round_nxt;
  logic        mix_idx_r, mix_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;

  logic        in_fire;
  logic [63:0] step_zero;
  logic [63:0] step_one;
  logic [63:0] word_sum;
  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_prod;
  logic [63:0] mix_fin;
  logic        poly_bit;

  // One generator step of the current state.
  function automatic logic [127:0] gen_step(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    logic [63:0] n0;
    logic [63:0] n1;
    t  = a ^ b;
    n0 = ((a << xrs128_pkg::ROT_A) | (a >> (64 - xrs128_pkg::ROT_A))) ^ t
         ^ (t << xrs128_pkg::SHIFT_B);
    n1 = (t << xrs128_pkg::ROT_C) | (t >> (64 - xrs128_pkg::ROT_C));
    return {n1, n0};
  endfunction

  assign {step_one, step_zero} = gen_step(word_zero_r, word_one_r);
  assign word_sum = word_zero_r + word_one_r;
  assign poly_bit = xrs128_pkg::JUMP_POLY[jump_cnt_r];

  // The shared multiplier: low 64 bits of z times a mixing constant are
  // built from three 32x32 products in ST_MUL_LL, ST_MUL_LH and ST_MUL_HL.
  assign mul_const = round_r ? xrs128_pkg::MIX_MUL_1 : xrs128_pkg::MIX_MUL_0;
  assign mul_a     = (state_r == xrs128_pkg::ST_MUL_HL) ? mix_z_r[63:32] : mix_z_r[31:0];
  assign mul_b     = (state_r == xrs128_pkg::ST_MUL_LH) ? mul_const[63:32] : mul_const[31:0];
  assign mul_prod  = 64'(mul_a) * 64'(mul_b);
  assign mix_fin   = mix_z_r ^ (mix_z_r >> xrs128_pkg::MIX_SH_2);

  assign in_ready  = (state_r == xrs128_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_random_value  = out_value_r;
  assign out_unit_fraction = out_value_r[63:xrs128_pkg::FRACTION_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xrs128_pkg::ST_IDLE;
      word_zero_r <= '0;
      word_one_r  <= '0;
      acc_zero_r  <= '0;
      acc_one_r   <= '0;
      jump_cnt_r  <= '0;
      round_r     <= 1'b0;
      mix_idx_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_zero_r <= word_zero_nxt;
      word_one_r  <= word_one_nxt;
      acc_zero_r  <= acc_zero_nxt;
      acc_one_r   <= acc_one_nxt;
      jump_cnt_r  <= jump_cnt_nxt;
      round_r     <= round_nxt;
      mix_idx_r   <= mix_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mix_z_r     <= mix_z_nxt;
    mul_acc_r   <= mul_acc_nxt;
    out_value_r <= out_value_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    word_zero_nxt = word_zero_r;
    word_one_nxt  = word_one_r;
    acc_zero_nxt  = acc_zero_r;
    acc_one_nxt   = acc_one_r;
    jump_cnt_nxt  = jump_cnt_r;
    mix_z_nxt     = mix_z_r;
    mul_acc_nxt   = mul_acc_r;
    round_nxt     = round_r;
    mix_idx_nxt   = mix_idx_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      xrs128_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            xrs128_pkg::KIND_SEED: begin
              mix_z_nxt   = in_seed_value;
              round_nxt   = 1'b0;
              mix_idx_nxt = 1'b0;
              state_nxt   = xrs128_pkg::ST_ADD;
            end
            xrs128_pkg::KIND_NEXT: begin
              out_value_nxt = word_sum;
              out_valid_nxt = 1'b1;
              word_zero_nxt = step_zero;
              word_one_nxt  = step_one;
            end
            xrs128_pkg::KIND_JUMP: begin
              acc_zero_nxt = '0;
              acc_one_nxt  = '0;
              jump_cnt_nxt = '0;
              state_nxt    = xrs128_pkg::ST_JUMP;
            end
            default: begin
              out_value_nxt = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      xrs128_pkg::ST_ADD: begin
        mix_z_nxt = mix_z_r + xrs128_pkg::MIX_GOLDEN;
        state_nxt = xrs128_pkg::ST_XS;
      end
      xrs128_pkg::ST_XS: begin
        mix_z_nxt = round_r ? (mix_z_r ^ (mix_z_r >> xrs128_pkg::MIX_SH_1))
                            : (mix_z_r ^ (mix_z_r >> xrs128_pkg::MIX_SH_0));
        state_nxt = xrs128_pkg::ST_MUL_LL;
      end
      xrs128_pkg::ST_MUL_LL: begin
        mul_acc_nxt = mul_prod;
        state_nxt   = xrs128_pkg::ST_MUL_LH;
      end
      xrs128_pkg::ST_MUL_LH: begin
        mul_acc_nxt = mul_acc_r + {mul_prod[31:0], 32'd0};
        state_nxt   = xrs128_pkg::ST_MUL_HL;
      end
      xrs128_pkg::ST_MUL_HL: begin
        mix_z_nxt = mul_acc_r + {mul_prod[31:0], 32'd0};
        if (!round_r) begin
          round_nxt = 1'b1;
          state_nxt = xrs128_pkg::ST_XS;
        end else begin
          state_nxt = xrs128_pkg::ST_FIN;
        end
      end
      xrs128_pkg::ST_FIN: begin
        round_nxt = 1'b0;
        if (!mix_idx_r) begin
          // First mix done: it becomes word zero and seeds the second mix.
          word_zero_nxt = mix_fin;
          mix_z_nxt     = mix_fin;
          mix_idx_nxt   = 1'b1;
          state_nxt     = xrs128_pkg::ST_ADD;
        end else begin
          word_one_nxt  = mix_fin;
          mix_idx_nxt   = 1'b0;
          out_value_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = xrs128_pkg::ST_IDLE;
        end
      end
      xrs128_pkg::ST_JUMP: begin
        acc_zero_nxt = acc_zero_r ^ (poly_bit ? word_zero_r : 64'd0);
        acc_one_nxt  = acc_one_r ^ (poly_bit ? word_one_r : 64'd0);
        if (jump_cnt_r == xrs128_pkg::JUMP_LAST) begin
          // The final step would be discarded, so load the sums directly.
          word_zero_nxt = acc_zero_nxt;
          word_one_nxt  = acc_one_nxt;
          acc_zero_nxt  = '0;
          acc_one_nxt   = '0;
          jump_cnt_nxt  = '0;
          out_value_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = xrs128_pkg::ST_IDLE;
        end else begin
          word_zero_nxt = step_zero;
          word_one_nxt  = step_one;
          jump_cnt_nxt  = jump_cnt_r + 7'd1;
        end
      end
      default: begin
        state_nxt = xrs128_pkg::ST_IDLE;
      end
    endcase
  end

  // While a seed or jump runs the output register is empty.
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != xrs128_pkg::ST_IDLE) |-> !out_valid_r)
    else $error("output word held during a seed or jump");

  a_jump_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (jump_cnt_r != 7'd0) |-> (state_r == xrs128_pkg::ST_JUMP))
    else $error("jump counter left running outside a jump");

  a_jump_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xrs128_pkg::ST_JUMP && jump_cnt_r == xrs128_pkg::JUMP_LAST)
    |=> (out_valid_r && out_value_r == 64'd0 && state_r == xrs128_pkg::ST_IDLE))
    else $error("jump did not finish with a zero result");

  a_next_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == xrs128_pkg::KIND_NEXT)
    |=> (out_valid_r && out_value_r == $past(word_sum)))
    else $error("next result is not the state sum");

endmodule

`default_nettype wire
